@@ hdl/lrusc_pkg.sv @@
// Shared types and constants for the LRU write-back sector cache directory.
// No dependencies; used by lrusc_cell, lrusc_chain and the top level.
package lrusc_pkg;

  // Default number of cache slots
  localparam int unsigned SLOTS_DEF = 64;
  // Sector number width
  localparam int unsigned SECTOR_W = 32;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACCESS    = 2'd0,
    KIND_WRITEBACK = 2'd1,
    KIND_FETCH     = 2'd2,
    KIND_DONE      = 2'd3
  } kind_e;

  // What the chain of recency cells does in a cycle
  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_TOUCH  = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_ROTATE = 2'd3
  } chain_mode_e;

  // Per-cell load control
  typedef struct packed {
    logic take_up;
    logic take_down;
  } cell_ctrl_t;

endpackage

@@ hdl/lrusc_cell.sv @@
// One recency position of the LRU chain: slot id, sector tag, valid and dirty.
// Depends on lrusc_pkg.
module lrusc_cell #(
  parameter int unsigned SLOT_W = 6,
  parameter int unsigned INDEX  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lrusc_pkg::cell_ctrl_t         ctrl_i,
  input  logic [lrusc_pkg::SECTOR_W-1:0] key_i,
  input  logic [SLOT_W-1:0]             up_slot_i,
  input  logic [lrusc_pkg::SECTOR_W-1:0] up_tag_i,
  input  logic                          up_valid_i,
  input  logic                          up_dirty_i,
  input  logic [SLOT_W-1:0]             dn_slot_i,
  input  logic [lrusc_pkg::SECTOR_W-1:0] dn_tag_i,
  input  logic                          dn_valid_i,
  input  logic                          dn_dirty_i,
  output logic [SLOT_W-1:0]             slot_o,
  output logic [lrusc_pkg::SECTOR_W-1:0] tag_o,
  output logic                          valid_o,
  output logic                          dirty_o,
  output logic                          match_o
);

  logic [SLOT_W-1:0]              slot_q, slot_d;
  logic [lrusc_pkg::SECTOR_W-1:0] tag_q, tag_d;
  logic                           valid_q, valid_d;
  logic                           dirty_q, dirty_d;

  // Select the neighbor to take from, else hold
  always_comb begin
    slot_d  = slot_q;
    tag_d   = tag_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (ctrl_i.take_up) begin
      slot_d  = up_slot_i;
      tag_d   = up_tag_i;
      valid_d = up_valid_i;
      dirty_d = up_dirty_i;
    end else if (ctrl_i.take_down) begin
      slot_d  = dn_slot_i;
      tag_d   = dn_tag_i;
      valid_d = dn_valid_i;
      dirty_d = dn_dirty_i;
    end
  end

  // Control state: slot id starts at this position's index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SLOT_W'(INDEX);
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
    end
  end

  // Tag is payload, only read while valid
  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign slot_o  = slot_q;
  assign tag_o   = tag_q;
  assign valid_o = valid_q;
  assign dirty_o = dirty_q;
  assign match_o = valid_q && (tag_q == key_i);

endmodule

@@ hdl/lrusc_chain.sv @@
// Row of recency cells, least recent at position 0, most recent at the top.
// Depends on lrusc_pkg and lrusc_cell.
module lrusc_chain #(
  parameter int unsigned SLOTS  = lrusc_pkg::SLOTS_DEF,
  parameter int unsigned SLOT_W = $clog2(SLOTS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lrusc_pkg::chain_mode_e         mode_i,
  input  logic [SLOTS-1:0]               prefix_i,
  input  logic [lrusc_pkg::SECTOR_W-1:0] key_i,
  input  logic [SLOT_W-1:0]              ins_slot_i,
  input  logic                           ins_dirty_i,
  output logic [SLOTS-1:0]               match_o,
  output logic [SLOT_W-1:0]              hit_slot_o,
  output logic                           hit_dirty_o,
  output logic [SLOT_W-1:0]              top_slot_o,
  output logic [lrusc_pkg::SECTOR_W-1:0] top_tag_o,
  output logic                           top_wb_o,
  output logic [SLOT_W-1:0]              bot_slot_o,
  output logic [lrusc_pkg::SECTOR_W-1:0] bot_tag_o,
  output logic                           bot_wb_o
);

  logic [SLOT_W-1:0]              slot_w  [SLOTS];
  logic [lrusc_pkg::SECTOR_W-1:0] tag_w   [SLOTS];
  logic                           valid_w [SLOTS];
  logic                           dirty_w [SLOTS];

  // Build the cells and wire each to its neighbors
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    lrusc_pkg::cell_ctrl_t          ctrl;
    logic [SLOT_W-1:0]              up_slot, dn_slot;
    logic [lrusc_pkg::SECTOR_W-1:0] up_tag, dn_tag;
    logic                           up_valid, dn_valid, up_dirty, dn_dirty;

    assign ctrl.take_up   = (mode_i == lrusc_pkg::MODE_INSERT) ||
                            ((mode_i == lrusc_pkg::MODE_TOUCH) && prefix_i[k]);
    assign ctrl.take_down = (mode_i == lrusc_pkg::MODE_ROTATE);

    // Top takes the touched or new entry, others take the one above
    if (k == SLOTS - 1) begin : g_top
      assign up_slot  = ins_slot_i;
      assign up_tag   = key_i;
      assign up_valid = 1'b1;
      assign up_dirty = ins_dirty_i;
    end else begin : g_mid
      assign up_slot  = slot_w[k+1];
      assign up_tag   = tag_w[k+1];
      assign up_valid = valid_w[k+1];
      assign up_dirty = dirty_w[k+1];
    end

    // Rotation closes the ring from the top back to position 0
    if (k == 0) begin : g_bot
      assign dn_slot  = slot_w[SLOTS-1];
      assign dn_tag   = tag_w[SLOTS-1];
      assign dn_valid = valid_w[SLOTS-1];
      assign dn_dirty = dirty_w[SLOTS-1];
    end else begin : g_low
      assign dn_slot  = slot_w[k-1];
      assign dn_tag   = tag_w[k-1];
      assign dn_valid = valid_w[k-1];
      assign dn_dirty = dirty_w[k-1];
    end

    lrusc_cell #(
      .SLOT_W (SLOT_W),
      .INDEX  (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .key_i      (key_i),
      .up_slot_i  (up_slot),
      .up_tag_i   (up_tag),
      .up_valid_i (up_valid),
      .up_dirty_i (up_dirty),
      .dn_slot_i  (dn_slot),
      .dn_tag_i   (dn_tag),
      .dn_valid_i (dn_valid),
      .dn_dirty_i (dn_dirty),
      .slot_o     (slot_w[k]),
      .tag_o      (tag_w[k]),
      .valid_o    (valid_w[k]),
      .dirty_o    (dirty_w[k]),
      .match_o    (match_o[k])
    );
  end

  // Pick slot id and dirty mark of the (at most one) matching cell
  always_comb begin
    hit_slot_o  = '0;
    hit_dirty_o = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      hit_slot_o  = hit_slot_o | (slot_w[k] & {SLOT_W{match_o[k]}});
      hit_dirty_o = hit_dirty_o | (dirty_w[k] & match_o[k]);
    end
  end

  assign top_slot_o = slot_w[SLOTS-1];
  assign top_tag_o  = tag_w[SLOTS-1];
  assign top_wb_o   = valid_w[SLOTS-1] && dirty_w[SLOTS-1];
  assign bot_slot_o = slot_w[0];
  assign bot_tag_o  = tag_w[0];
  assign bot_wb_o   = valid_w[0] && dirty_w[0];

endmodule

@@ hdl/lru_writeback_sector_cache_top.sv @@
// Top level of the LRU write-back sector cache directory: control FSM and outputs.
// Depends on lrusc_pkg and lrusc_chain.
//
// A transaction is taken when start is high and busy is low. Each result is
// shown for one cycle with valid_o high and must be taken in that cycle; the
// receiver cannot stall the block. A read or write hit passes through the
// lookup and hit states and gives its result from the hit state. A miss
// runs a write-back state only when the least recent slot is dirty, then
// fetch and access, emitting one result per cycle: write-back, fetch, then
// access. A flush walks the recency chain by rotating it one position per
// cycle through the whole ring whatever the number of dirty slots; an empty
// flush answers with a single done result. Opcode 3 is taken and ignored.
module lru_writeback_sector_cache_top #(
  parameter int unsigned SLOTS = lrusc_pkg::SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode_i,
  input  logic [lrusc_pkg::SECTOR_W-1:0] sector_i,
  output logic                           valid_o,
  output logic [1:0]                     kind_o,
  output logic [$clog2(SLOTS)-1:0]       slot_o,
  output logic [lrusc_pkg::SECTOR_W-1:0] sector_res_o,
  output logic                           hit_o,
  output logic                           last_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned LVL    = $clog2(SLOTS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_HIT   = 7'b0000100,
    S_WB    = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  logic                           wr_q, wr_d;
  logic [lrusc_pkg::SECTOR_W-1:0] key_q, key_d;
  logic [SLOTS-1:0]               pre_q, pre_d;
  logic [SLOT_W-1:0]              hslot_q, hslot_d;
  logic                           hdirty_q, hdirty_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [CNT_W-1:0]               rem_q, rem_d;
  logic [SLOT_W-1:0]              rot_q, rot_d;

  logic                           vld_q, vld_d;
  logic [1:0]                     kind_q, kind_d;
  logic [SLOT_W-1:0]              slot_q, slot_d;
  logic [lrusc_pkg::SECTOR_W-1:0] sec_q, sec_d;
  logic                           hit_q, hit_d;
  logic                           last_q, last_d;

  lrusc_pkg::chain_mode_e         mode;
  logic [SLOT_W-1:0]              ins_slot;
  logic                           ins_dirty;
  logic [SLOTS-1:0]               match;
  logic [SLOTS-1:0]               prefix;
  logic [SLOT_W-1:0]              hit_slot, top_slot, bot_slot;
  logic                           hit_dirty, top_wb, bot_wb;
  logic [lrusc_pkg::SECTOR_W-1:0] top_tag, bot_tag;

  lrusc_chain #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode),
    .prefix_i    (pre_q),
    .key_i       (key_q),
    .ins_slot_i  (ins_slot),
    .ins_dirty_i (ins_dirty),
    .match_o     (match),
    .hit_slot_o  (hit_slot),
    .hit_dirty_o (hit_dirty),
    .top_slot_o  (top_slot),
    .top_tag_o   (top_tag),
    .top_wb_o    (top_wb),
    .bot_slot_o  (bot_slot),
    .bot_tag_o   (bot_tag),
    .bot_wb_o    (bot_wb)
  );

  // Mark every position at or above the hit (log-depth prefix OR)
  always_comb begin
    prefix = match;
    for (int l = 0; l < LVL; l++) begin
      prefix = prefix | (prefix << (1 << l));
    end
  end

  // Sequence the request and build the next result
  always_comb begin
    state_d   = state_q;
    wr_d      = wr_q;
    key_d     = key_q;
    pre_d     = pre_q;
    hslot_d   = hslot_q;
    hdirty_d  = hdirty_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    rot_d     = rot_q;
    mode      = lrusc_pkg::MODE_HOLD;
    ins_slot  = hslot_q;
    ins_dirty = hdirty_q | wr_q;
    vld_d     = 1'b0;
    kind_d    = lrusc_pkg::KIND_ACCESS;
    slot_d    = '0;
    sec_d     = '0;
    hit_d     = 1'b0;
    last_d    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (opcode_i)
            lrusc_pkg::OP_READ, lrusc_pkg::OP_WRITE: begin
              wr_d    = (opcode_i == lrusc_pkg::OP_WRITE);
              key_d   = sector_i;
              state_d = S_LOOK;
            end
            lrusc_pkg::OP_FLUSH: begin
              if (cnt_q == '0) begin
                vld_d  = 1'b1;
                kind_d = lrusc_pkg::KIND_DONE;
                last_d = 1'b1;
              end else begin
                rem_d   = cnt_q;
                rot_d   = '0;
                state_d = S_FLUSH;
              end
            end
            lrusc_pkg::OP_NONE: begin
              state_d = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_LOOK: begin
        pre_d    = prefix;
        hslot_d  = hit_slot;
        hdirty_d = hit_dirty;
        if (|match) begin
          state_d = S_HIT;
        end else if (bot_wb) begin
          state_d = S_WB;
        end else begin
          state_d = S_FETCH;
        end
      end

      S_HIT: begin
        mode   = lrusc_pkg::MODE_TOUCH;
        vld_d  = 1'b1;
        kind_d = lrusc_pkg::KIND_ACCESS;
        slot_d = hslot_q;
        sec_d  = key_q;
        hit_d  = 1'b1;
        last_d = 1'b1;
        if (wr_q && !hdirty_q) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end

      S_WB: begin
        vld_d   = 1'b1;
        kind_d  = lrusc_pkg::KIND_WRITEBACK;
        slot_d  = bot_slot;
        sec_d   = bot_tag;
        state_d = S_FETCH;
      end

      S_FETCH: begin
        mode      = lrusc_pkg::MODE_INSERT;
        ins_slot  = bot_slot;
        ins_dirty = wr_q;
        vld_d     = 1'b1;
        kind_d    = lrusc_pkg::KIND_FETCH;
        slot_d    = bot_slot;
        sec_d     = key_q;
        cnt_d     = cnt_q + CNT_W'(wr_q) - CNT_W'(bot_wb);
        state_d   = S_ACC;
      end

      S_ACC: begin
        vld_d   = 1'b1;
        kind_d  = lrusc_pkg::KIND_ACCESS;
        slot_d  = top_slot;
        sec_d   = key_q;
        last_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_FLUSH: begin
        // Rotate the ring; the top shows positions from most to least recent
        mode = lrusc_pkg::MODE_ROTATE;
        if (top_wb) begin
          vld_d  = 1'b1;
          kind_d = lrusc_pkg::KIND_WRITEBACK;
          slot_d = top_slot;
          sec_d  = top_tag;
          last_d = (rem_q == CNT_W'(1));
          rem_d  = rem_q - CNT_W'(1);
        end
        rot_d = rot_q + SLOT_W'(1);
        if (rot_q == SLOT_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      rot_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      rot_q   <= rot_d;
      vld_q   <= vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wr_q     <= wr_d;
    key_q    <= key_d;
    pre_q    <= pre_d;
    hslot_q  <= hslot_d;
    hdirty_q <= hdirty_d;
    kind_q   <= kind_d;
    slot_q   <= slot_d;
    sec_q    <= sec_d;
    hit_q    <= hit_d;
    last_q   <= last_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign valid_o      = vld_q;
  assign kind_o       = kind_q;
  assign slot_o       = slot_q;
  assign sector_res_o = sec_q;
  assign hit_o        = hit_q;
  assign last_o       = last_q;

endmodule

@@ dv/lru_writeback_sector_cache_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lru_writeback_sector_cache_top: directed and random requests,
// results checked in order against a behavioral LRU directory model. Depends on lrusc_pkg.
module lru_writeback_sector_cache_top_tb;

  localparam int unsigned SLOTS = lrusc_pkg::SLOTS_DEF;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned CALM_TAIL = 60;
  localparam int unsigned POOL_SIZE = 80;
  localparam int unsigned WATCHDOG_LIMIT = 20 * (SLOTS + 16);

  // One order or access result as the block shows it
  typedef struct {
    lrusc_pkg::kind_e                kind;
    logic [SLOT_W-1:0]               slot;
    logic [lrusc_pkg::SECTOR_W-1:0]  sector;
    logic                            hit;
    logic                            last;
  } cache_order_t;

  // Behavioral directory: tags, valid/dirty marks and recency order, plus the
  // orders still owed by the block in the order they must appear.
  class sector_dir_predictor;
    logic [lrusc_pkg::SECTOR_W-1:0] tag_q [SLOTS];
    bit                  valid_q [SLOTS];
    bit                  dirty_q [SLOTS];
    int unsigned         lru_pos [SLOTS];  // position 0 is least recent
    cache_order_t        pending_q [$];
    int unsigned         mismatches;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        tag_q[s] = '0;
        valid_q[s] = 1'b0;
        dirty_q[s] = 1'b0;
        lru_pos[s] = s;
      end
      mismatches = 0;
    endfunction

    // Move a slot to the most recent position
    function void promote(int unsigned s);
      int p;
      p = 0;
      while (p < SLOTS && lru_pos[p] != s) p++;
      for (int k = p; k < SLOTS - 1; k++) lru_pos[k] = lru_pos[k + 1];
      lru_pos[SLOTS - 1] = s;
    endfunction

    function void add_order(lrusc_pkg::kind_e kind, int unsigned s,
                            logic [lrusc_pkg::SECTOR_W-1:0] sec, bit hit, bit last);
      cache_order_t o;
      o.kind = kind;
      o.slot = s[SLOT_W-1:0];
      o.sector = sec;
      o.hit = hit;
      o.last = last;
      pending_q.push_back(o);
    endfunction

    // Work out the orders caused by one accepted request transaction
    function void take_request(logic [1:0] op, logic [lrusc_pkg::SECTOR_W-1:0] sec);
      int unsigned total;
      int unsigned sent;
      int unsigned victim;
      int          hit_slot;
      total = 0;
      sent = 0;
      hit_slot = -1;
      case (op)
        lrusc_pkg::OP_FLUSH: begin
          for (int s = 0; s < SLOTS; s++) if (valid_q[s] && dirty_q[s]) total++;
          if (total == 0) begin
            add_order(lrusc_pkg::KIND_DONE, 0, '0, 1'b0, 1'b1);
          end else begin
            // Walk from most recent to least recent; dirty marks stay set
            for (int p = SLOTS - 1; p >= 0; p--) begin
              victim = lru_pos[p];
              if (valid_q[victim] && dirty_q[victim]) begin
                sent++;
                add_order(lrusc_pkg::KIND_WRITEBACK, victim, tag_q[victim], 1'b0,
                          sent == total);
              end
            end
          end
        end
        lrusc_pkg::OP_READ, lrusc_pkg::OP_WRITE: begin
          for (int s = 0; s < SLOTS; s++)
            if (hit_slot < 0 && valid_q[s] && tag_q[s] == sec) hit_slot = s;
          if (hit_slot >= 0) begin
            promote(unsigned'(hit_slot));
            if (op == lrusc_pkg::OP_WRITE) dirty_q[hit_slot] = 1'b1;
            add_order(lrusc_pkg::KIND_ACCESS, unsigned'(hit_slot), sec, 1'b1, 1'b1);
          end else begin
            // Reuse the least recent slot; write it back first if dirty
            victim = lru_pos[0];
            if (valid_q[victim] && dirty_q[victim])
              add_order(lrusc_pkg::KIND_WRITEBACK, victim, tag_q[victim], 1'b0, 1'b0);
            add_order(lrusc_pkg::KIND_FETCH, victim, sec, 1'b0, 1'b0);
            tag_q[victim] = sec;
            valid_q[victim] = 1'b1;
            dirty_q[victim] = (op == lrusc_pkg::OP_WRITE);
            promote(victim);
            add_order(lrusc_pkg::KIND_ACCESS, victim, sec, 1'b0, 1'b1);
          end
        end
        default: ;  // unused opcode: no state change, no result
      endcase
    endfunction

    // Compare one result against the oldest owed order
    function void match_result(logic [1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [lrusc_pkg::SECTOR_W-1:0] sec, logic hit, logic last);
      cache_order_t o;
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("error: unexpected result kind=%0d slot=%0d sector=%h hit=%b last=%b",
                   kind, slot, sec, hit, last);
        mismatches++;
        return;
      end
      o = pending_q.pop_front();
      if (kind !== o.kind || slot !== o.slot || sec !== o.sector ||
          hit !== o.hit || last !== o.last) begin
        if (mismatches < 10)
          $display("error: expected kind=%0d slot=%0d sector=%h hit=%b last=%b,",
                   o.kind, o.slot, o.sector, o.hit, o.last,
                   " got kind=%0d slot=%0d sector=%h hit=%b last=%b",
                   kind, slot, sec, hit, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              opcode_i = lrusc_pkg::OP_READ;
  logic [lrusc_pkg::SECTOR_W-1:0] sector_i = '0;
  logic                    valid_o;
  logic [1:0]              kind_o;
  logic [SLOT_W-1:0]       slot_o;
  logic [lrusc_pkg::SECTOR_W-1:0] sector_res_o;
  logic                    hit_o;
  logic                    last_o;

  sector_dir_predictor     dir_model;
  logic [lrusc_pkg::SECTOR_W-1:0] sector_pool [POOL_SIZE];
  int unsigned             quiet_cycles = 0;

  lru_writeback_sector_cache_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .sector_i     (sector_i),
    .valid_o      (valid_o),
    .kind_o       (kind_o),
    .slot_o       (slot_o),
    .sector_res_o (sector_res_o),
    .hit_o        (hit_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(logic [1:0] op, logic [lrusc_pkg::SECTOR_W-1:0] sec);
    @(negedge clk_i);
    start <= 1'b1;
    opcode_i <= op;
    sector_i <= sec;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for a few cycles and put noise on the request fields
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
      opcode_i <= 2'($urandom_range(0, 3));
      sector_i <= $urandom;
    end
  endtask

  // Hold off until every owed result has come out
  task automatic drain_orders();
    @(negedge clk_i);
    start <= 1'b0;
    while (dir_model.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Check results, record accepted requests and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) dir_model.match_result(kind_o, slot_o, sector_res_o, hit_o, last_o);
      if (start && !busy) dir_model.take_request(opcode_i, sector_i);
      if (valid_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [1:0]  op;
    logic [lrusc_pkg::SECTOR_W-1:0] sec;

    dir_model = new();
    // Working set a bit larger than the cache, so hits and evictions both occur
    foreach (sector_pool[k]) sector_pool[k] = $urandom;
    sector_pool[0] = '0;
    sector_pool[1] = '1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty flush, sector extremes, hits, unused opcode, small flushes
    send_request(lrusc_pkg::OP_FLUSH, 32'h1234_5678);
    send_request(lrusc_pkg::OP_READ, 32'h0000_0000);
    send_request(lrusc_pkg::OP_WRITE, 32'hFFFF_FFFF);
    send_request(lrusc_pkg::OP_READ, 32'hFFFF_FFFF);
    send_request(lrusc_pkg::OP_WRITE, 32'h0000_0000);
    send_request(lrusc_pkg::OP_NONE, 32'h5A5A_A5A5);
    send_request(lrusc_pkg::OP_FLUSH, 32'h0000_0000);
    send_request(lrusc_pkg::OP_READ, 32'h8000_0000);
    send_request(lrusc_pkg::OP_WRITE, 32'h0000_0001);
    send_request(lrusc_pkg::OP_READ, 32'h0000_0001);
    send_request(lrusc_pkg::OP_READ, 32'h7FFF_FFFE);
    send_request(lrusc_pkg::OP_FLUSH, 32'hFFFF_FFFF);
    send_request(lrusc_pkg::OP_NONE, 32'h0000_0000);
    send_request(lrusc_pkg::OP_WRITE, 32'h8000_0000);
    drain_orders();

    // Random: mostly working-set reads and writes, some flushes and noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS - CALM_TAIL) begin
        if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 11));
        if ($urandom_range(0, 49) == 0) drain_orders();
      end
      pick = $urandom_range(0, 99);
      if (pick < 48) op = lrusc_pkg::OP_READ;
      else if (pick < 88) op = lrusc_pkg::OP_WRITE;
      else if (pick < 95) op = lrusc_pkg::OP_FLUSH;
      else op = lrusc_pkg::OP_NONE;
      if ($urandom_range(0, 9) == 0) sec = $urandom;
      else sec = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(op, sec);
    end

    // Wait out the remaining results and any trailing work
    @(negedge clk_i);
    start <= 1'b0;
    while (dir_model.pending_q.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
    if (dir_model.mismatches == 0 && dir_model.pending_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
